// ===== hdl/ritoa_pkg.sv =====
`timescale 1ns / 1ps

package ritoa_pkg;

   // Width of the converted value
   localparam int NUM_BITS = 32;

   // Dividend bits consumed per divide cycle
   localparam int CHUNK    = 8;
   localparam int STEPS    = (NUM_BITS + CHUNK - 1) / CHUNK;
   localparam int PAD_BITS = STEPS * CHUNK;
   localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

   // Digit store addressing and digit count
   localparam int IDX_W    = $clog2(NUM_BITS);
   localparam int CNT_W    = $clog2(NUM_BITS + 1);

   // Base limits
   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;

   // Format flag bit positions
   localparam int FLAG_UNSIGNED = 0;
   localparam int FLAG_LOWER    = 1;

   // ASCII codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef struct packed {
      logic [31:0] number;
      logic [4:0]  radix;
      logic [1:0]  format_flags;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic step_last;
      logic quot_zero;
      logic negative;
      logic one_left;
      logic out_free;
   } status_type;

   // Digit value to ASCII, upper or lower case letters
   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic lower);
      logic [7:0] result;
      if (digit < 4'd10) begin
         result = CHAR_ZERO + {4'd0, digit};
      end else if (lower) begin
         result = CHAR_LOWER_A + {4'd0, digit} - 8'd10;
      end else begin
         result = CHAR_UPPER_A + {4'd0, digit} - 8'd10;
      end
      return result;
   endfunction

endpackage

// ===== hdl/ritoa_ctrl.sv =====
`timescale 1ns / 1ps

module ritoa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ritoa_pkg::status_type  status,
   output ritoa_pkg::cmd_type     cmd
);
   import ritoa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            // quotient gone to zero: all digits are stored
            if (status.step_last && status.quot_zero) begin
               state_in = status.negative ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/ritoa_dp.sv =====
`timescale 1ns / 1ps

module ritoa_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ritoa_pkg::req_type     req_data,
   input  ritoa_pkg::cmd_type     cmd,
   output ritoa_pkg::status_type  status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ritoa_pkg::rsp_type     rsp_data
);
   import ritoa_pkg::*;

   logic [PAD_BITS-1:0] div_ff;
   logic [3:0]          rem_ff;
   logic [4:0]          base_ff;
   logic                lower_ff;
   logic                neg_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [3:0]          digits_ff [NUM_BITS];
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [NUM_BITS-1:0] raw;
   logic                neg_in;
   logic [NUM_BITS-1:0] mag;
   logic [4:0]          base_in;
   logic [PAD_BITS-1:0] div_next;
   logic [3:0]          rem_next;
   logic [4:0]          trial;
   logic [CNT_W-1:0]    cnt_dec;
   logic [IDX_W-1:0]    rd_idx;
   logic                step_last;
   logic                out_free;

   // Input decode: saturated base and two's complement magnitude
   always_comb begin
      raw    = NUM_BITS'(req_data.number);
      neg_in = !req_data.format_flags[FLAG_UNSIGNED] && raw[NUM_BITS-1];
      mag    = neg_in ? (~raw + NUM_BITS'(1)) : raw;
      if (req_data.radix < RADIX_MIN) begin
         base_in = RADIX_MIN;
      end else if (req_data.radix > RADIX_MAX) begin
         base_in = RADIX_MAX;
      end else begin
         base_in = req_data.radix;
      end
   end

   // Restoring division by the base, CHUNK dividend bits per cycle
   always_comb begin
      div_next = div_ff;
      rem_next = rem_ff;
      trial    = '0;
      for (int i = 0; i < CHUNK; i++) begin
         trial    = {rem_next, div_next[PAD_BITS-1]};
         div_next = {div_next[PAD_BITS-2:0], 1'b0};
         if (trial >= base_ff) begin
            rem_next    = 4'(trial - base_ff);
            div_next[0] = 1'b1;
         end else begin
            rem_next = trial[3:0];
         end
      end
   end

   assign cnt_dec   = count_ff - CNT_W'(1);
   assign rd_idx    = cnt_dec[IDX_W-1:0];
   assign step_last = (step_ff == STEP_W'(STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.step_last = step_last;
   assign status.quot_zero = (div_next == '0);
   assign status.negative  = neg_ff;
   assign status.one_left  = (count_ff == CNT_W'(1));
   assign status.out_free  = out_free;

   // Working registers and output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= '0;
         rem_ff       <= '0;
         neg_ff       <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            div_ff   <= PAD_BITS'(mag);
            rem_ff   <= '0;
            neg_ff   <= neg_in;
            step_ff  <= '0;
            count_ff <= '0;
         end
         if (cmd.step) begin
            div_ff <= div_next;
            if (step_last) begin
               rem_ff   <= '0;
               step_ff  <= '0;
               count_ff <= count_ff + CNT_W'(1);
            end else begin
               rem_ff  <= rem_next;
               step_ff <= step_ff + STEP_W'(1);
            end
         end
         if (cmd.emit_digit) begin
            count_ff <= cnt_dec;
         end
         if (cmd.emit_sign || cmd.emit_digit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Format flags and base, held for the whole item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff  <= base_in;
         lower_ff <= req_data.format_flags[FLAG_LOWER];
      end
   end

   // Digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (cmd.step && step_last) begin
         digits_ff[count_ff[IDX_W-1:0]] <= rem_next;
      end
   end

   // Output word payload
   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_ff.character <= CHAR_MINUS;
         rsp_ff.last      <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_ff.character <= digit_char(digits_ff[rd_idx], lower_ff);
         rsp_ff.last      <= (count_ff == CNT_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/radix_integer_to_ascii_unit.sv =====
`timescale 1ns / 1ps

// Converts a 32-bit integer to ASCII text in a base from 2 to 16, most
// significant character first, one word per character, with last set on the
// final one. In signed mode a negative value gives '-' and then its
// magnitude; the most negative value prints exactly. Bases below 2 or above
// 16 are clamped. An item is loaded, then each digit is found in the divider
// (8 dividend bits per cycle through a restoring divider by the base), least
// significant first, then the characters go out through the output register,
// which holds each word while the result side stalls. A new item is taken as
// soon as the final character is in the output register, even while that
// word still waits to be taken.
module radix_integer_to_ascii_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ritoa_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ritoa_pkg::rsp_type rsp_data
);
   import ritoa_pkg::*;

   cmd_type    cmd;
   status_type status;

   ritoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ritoa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ritoa_pkg::*;

   // Holds the characters still owed by the block and checks each word
   // against the oldest of them
   class itoa_scoreboard;
      rsp_type owed_chars[$];
      int      errors = 0;

      // Work out the text of an accepted number and queue its characters
      function void note_number(req_type item);
         logic [31:0] magnitude;
         logic [31:0] base;
         logic [3:0]  digits[NUM_BITS];
         int          count;
         logic        negative;
         logic        lower;
         rsp_type     word;
         base = {27'd0, item.radix};
         if (item.radix < RADIX_MIN) begin
            base = {27'd0, RADIX_MIN};
         end else if (item.radix > RADIX_MAX) begin
            base = {27'd0, RADIX_MAX};
         end
         lower    = item.format_flags[FLAG_LOWER];
         negative = !item.format_flags[FLAG_UNSIGNED] && item.number[NUM_BITS-1];
         // two's complement magnitude, exact for the most negative value
         magnitude = negative ? (~item.number + 32'd1) : item.number;
         count = 0;
         do begin
            digits[count] = 4'(magnitude % base);
            count++;
            magnitude = magnitude / base;
         end while (magnitude != 32'd0);
         if (negative) begin
            word.character = CHAR_MINUS;
            word.last      = 1'b0;
            owed_chars.push_back(word);
         end
         for (int i = count - 1; i >= 0; i--) begin
            if (digits[i] < 4'd10) begin
               word.character = CHAR_ZERO + {4'd0, digits[i]};
            end else begin
               word.character = (lower ? CHAR_LOWER_A : CHAR_UPPER_A)
                                + {4'd0, digits[i]} - 8'd10;
            end
            word.last = (i == 0);
            owed_chars.push_back(word);
         end
      endfunction

      // Compare one accepted result word field by field
      function void check_char(rsp_type got);
         rsp_type want;
         if (owed_chars.size() == 0) begin
            $display("%0t: unexpected word, character %h last %b",
                     $time, got.character, got.last);
            errors++;
         end else begin
            want = owed_chars.pop_front();
            if (got.character !== want.character) begin
               $display("%0t: character mismatch, expected %h actual %h",
                        $time, want.character, got.character);
               errors++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last mismatch, expected %b actual %b",
                        $time, want.last, got.last);
               errors++;
            end
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   itoa_scoreboard board = new;

   radix_integer_to_ascii_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Result words checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_char(rsp_data);
      end
   end

   // Present one number; entered and left just after a falling edge
   task automatic send_number(input logic [31:0] number, input logic [4:0] radix,
                              input logic [1:0] flags);
      req_type item;
      item.number       = number;
      item.radix        = radix;
      item.format_flags = flags;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_number(item);
      @(negedge clock);
   endtask

   // Hold off until every owed character has come out
   task automatic drain_output();
      req_valid <= 1'b0;
      while (board.owed_chars.size() != 0) @(negedge clock);
   endtask

   // Mostly values near the awkward edges, with a share of plain random values
   function automatic logic [31:0] pick_number();
      int unsigned shift;
      shift = $urandom_range(31);
      case ($urandom_range(7))
         0:       return 32'($urandom_range(20));
         1:       return 32'd1 << shift;
         2:       return (32'd1 << shift) - 32'd1;
         3:       return 32'h8000_0000 + 32'($urandom_range(3));
         4:       return 32'd0 - 32'($urandom_range(20));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [4:0] pick_radix();
      case ($urandom_range(9))
         0:       return 5'($urandom_range(31));
         1:       return 5'd10;
         2:       return 5'd16;
         default: return 5'($urandom_range(2, 16));
      endcase
   endfunction

   task automatic random_phase(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         send_number(pick_number(), pick_radix(), 2'($urandom_range(3)));
      end
      drain_output();
   endtask

   // Stimulus
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 73;
      // zero, extremes and every flag combination
      send_number(32'd0,          5'd10, 2'b00);
      send_number(32'd0,          5'd2,  2'b01);
      send_number(32'h8000_0000,  5'd10, 2'b00);
      send_number(32'h8000_0000,  5'd10, 2'b01);
      send_number(32'h8000_0000,  5'd2,  2'b00);
      send_number(32'hFFFF_FFFF,  5'd2,  2'b01);
      send_number(32'hFFFF_FFFF,  5'd2,  2'b00);
      send_number(32'hFFFF_FFFF,  5'd16, 2'b11);
      send_number(32'h7FFF_FFFF,  5'd16, 2'b00);
      send_number(32'h7FFF_FFFF,  5'd16, 2'b10);
      send_number(32'hABCD_EF01,  5'd16, 2'b11);
      send_number(32'hABCD_EF01,  5'd16, 2'b01);
      send_number(32'hABCD_EF01,  5'd16, 2'b10);
      send_number(32'd123456789,  5'd10, 2'b00);
      // base saturation at both ends
      send_number(32'd255,        5'd0,  2'b00);
      send_number(32'd255,        5'd1,  2'b01);
      send_number(32'hDEAD_BEEF,  5'd17, 2'b11);
      send_number(32'hDEAD_BEEF,  5'd31, 2'b01);
      send_number(32'hFFFF_FFF6,  5'd31, 2'b10);
      send_number(32'd1,          5'd3,  2'b00);
      send_number(32'hFFFF_FFFF,  5'd3,  2'b01);
      send_number(32'hFFFF_FFFF,  5'd7,  2'b00);
      send_number(32'd35,         5'd15, 2'b10);
      drain_output();

      random_phase(124, 26, 73);
      random_phase(123, 73, 26);
      random_phase(123, 0, 0);

      repeat (200) @(negedge clock);
      if (board.errors == 0 && board.owed_chars.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ritoa_pkg.sv
hdl/ritoa_ctrl.sv
hdl/ritoa_dp.sv
hdl/radix_integer_to_ascii_unit.sv
bench/testbench.sv
